/* design/lateral_shower_moment_macros.svh */
// Assertion macros for the lateral shower moment block.
// Used by the port checker; depends on nothing else.
`ifndef LATERAL_SHOWER_MOMENT_MACROS_SVH
`define LATERAL_SHOWER_MOMENT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LSM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define LSM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lsm_pkg.sv */
// Shared types and constants for the lateral shower moment block.
// No dependencies.
package lsm_pkg;

    localparam int ENERGY_W   = 16;
    localparam int RADIUS_W   = 16;
    localparam int SPACING_W  = 20;
    localparam int FRAC_W     = 16;
    localparam int SQ_W       = 2 * RADIUS_W;
    localparam int TERM_W     = SQ_W + ENERGY_W;
    localparam int SUM_W      = 56;
    localparam int ESUM_W     = ENERGY_W + 1;
    localparam int CORE_W     = SPACING_W + ESUM_W;
    localparam int DEN_W      = SUM_W + 1;
    localparam int REM_W      = SUM_W + 2;
    localparam int DIV_CW     = 4;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(25600);
    localparam logic [DIV_CW-1:0]    DIV_LAST      = DIV_CW'(FRAC_W - 1);
    localparam logic                 REG_SPACING   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_MULT,
        S_ACC,
        S_CORE,
        S_DEN,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic mult;
        logic acc;
        logic core;
        logic den;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

endpackage

/* design/lsm_ctrl.sv */
// Controller state machine for the lateral shower moment block.
// Depends on lsm_pkg; drives the datapath through cmd_t.
module lsm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lsm_pkg::status_t status,
    output lsm_pkg::cmd_t    cmd
);
    import lsm_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [DIV_CW-1:0]   step_reg;
    logic [DIV_CW-1:0]   step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: state_next = S_MULT;
            S_MULT:   state_next = S_ACC;
            S_ACC:    state_next = status.last ? S_CORE : S_IDLE;
            S_CORE:   state_next = S_DEN;
            S_DEN:
            begin
                state_next = S_DIV;
                step_next  = '0;
            end
            S_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SQUARE: cmd.square   = 1'b1;
            S_MULT:   cmd.mult     = 1'b1;
            S_ACC:    cmd.acc      = 1'b1;
            S_CORE:   cmd.core     = 1'b1;
            S_DEN:    cmd.den      = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_OUT:    cmd.finish   = status.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule

/* design/lsm_datapath.sv */
// Datapath for the lateral shower moment block: ranking, multiply-accumulate,
// denominator and restoring divider, output register. Depends on lsm_pkg.
module lsm_datapath
#(
    parameter int MAX_CRYSTALS = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lsm_pkg::cmd_t                  cmd,
    output lsm_pkg::status_t               status,
    input  logic [lsm_pkg::SPACING_W-1:0]  spacing_squared,
    input  logic [lsm_pkg::ENERGY_W-1:0]   energy,
    input  logic [lsm_pkg::RADIUS_W-1:0]   radius,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lsm_pkg::FRAC_W-1:0]     lat_fraction,
    output logic                           too_few,
    output logic                           zero_denominator
);
    import lsm_pkg::*;

    localparam int CNT_W = $clog2(MAX_CRYSTALS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CRYSTALS);

    logic [ENERGY_W-1:0] top_energy_reg;
    logic [RADIUS_W-1:0] top_radius_reg;
    logic [ENERGY_W-1:0] second_energy_reg;
    logic [RADIUS_W-1:0] second_radius_reg;
    logic [SUM_W-1:0]    reduced_sum_reg;
    logic [CNT_W-1:0]    crystal_count_reg;
    logic                last_reg;

    logic [ENERGY_W-1:0] acc_energy_reg;
    logic [RADIUS_W-1:0] acc_radius_reg;
    logic                acc_en_reg;
    logic [SQ_W-1:0]     square_reg;
    logic [TERM_W-1:0]   term_reg;

    logic [CORE_W-1:0]   core_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [FRAC_W-1:0]   quo_reg;
    logic                sat_reg;

    logic                out_valid_reg;
    logic [FRAC_W-1:0]   lat_reg;
    logic                few_reg;
    logic                zden_reg;

    logic [SUM_W:0]      sum_wide;
    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    den_ext;
    logic                rem_ge;
    logic                few_now;
    logic                zden_now;
    logic [DEN_W-1:0]    den_sum;

    assign sum_wide  = {1'b0, reduced_sum_reg} + (SUM_W+1)'(term_reg);
    assign rem_shift = {rem_reg[REM_W-2:0], 1'b0};
    assign den_ext   = REM_W'(den_reg);
    assign rem_ge    = rem_shift >= den_ext;
    assign few_now   = crystal_count_reg < CNT_W'(3);
    assign zden_now  = den_reg == '0;
    assign den_sum   = DEN_W'(reduced_sum_reg) + DEN_W'(core_reg);

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // Rank the new crystal, pick the one that leaves the top two; MAC, divide
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_en_reg <= 1'b0;
            if (crystal_count_reg == '0)
            begin
                top_energy_reg <= energy;
                top_radius_reg <= radius;
            end
            else if (crystal_count_reg == CNT_W'(1))
            begin
                if (energy > top_energy_reg)
                begin
                    second_energy_reg <= top_energy_reg;
                    second_radius_reg <= top_radius_reg;
                    top_energy_reg    <= energy;
                    top_radius_reg    <= radius;
                end
                else
                begin
                    second_energy_reg <= energy;
                    second_radius_reg <= radius;
                end
            end
            else if (energy > top_energy_reg)
            begin
                acc_en_reg        <= 1'b1;
                acc_energy_reg    <= second_energy_reg;
                acc_radius_reg    <= second_radius_reg;
                second_energy_reg <= top_energy_reg;
                second_radius_reg <= top_radius_reg;
                top_energy_reg    <= energy;
                top_radius_reg    <= radius;
            end
            else if (energy > second_energy_reg)
            begin
                acc_en_reg        <= 1'b1;
                acc_energy_reg    <= second_energy_reg;
                acc_radius_reg    <= second_radius_reg;
                second_energy_reg <= energy;
                second_radius_reg <= radius;
            end
            else
            begin
                acc_en_reg     <= 1'b1;
                acc_energy_reg <= energy;
                acc_radius_reg <= radius;
            end
        end
        else if (cmd.finish)
        begin
            top_energy_reg    <= '0;
            top_radius_reg    <= '0;
            second_energy_reg <= '0;
            second_radius_reg <= '0;
        end
        if (cmd.load)
        begin
            last_reg <= last;
        end
        if (cmd.square)
        begin
            square_reg <= acc_radius_reg * acc_radius_reg;
        end
        if (cmd.mult)
        begin
            term_reg <= square_reg * acc_energy_reg;
        end
        if (cmd.core)
        begin
            core_reg <= spacing_squared *
                        (ESUM_W'(top_energy_reg) + ESUM_W'(second_energy_reg));
        end
        if (cmd.den)
        begin
            den_reg <= den_sum;
            rem_reg <= REM_W'(reduced_sum_reg);
            sat_reg <= DEN_W'(reduced_sum_reg) >= den_sum;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_shift - den_ext : rem_shift;
            quo_reg <= {quo_reg[FRAC_W-2:0], rem_ge};
        end
        if (cmd.finish)
        begin
            few_reg  <= few_now;
            zden_reg <= !few_now && zden_now;
            if (few_now || zden_now)
            begin
                lat_reg <= '0;
            end
            else if (sat_reg)
            begin
                lat_reg <= '1;
            end
            else
            begin
                lat_reg <= quo_reg;
            end
        end
    end

    // Cluster sum and count, cleared after each result; output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduced_sum_reg   <= '0;
            crystal_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                reduced_sum_reg   <= '0;
                crystal_count_reg <= '0;
            end
            else
            begin
                if (cmd.acc && acc_en_reg)
                begin
                    reduced_sum_reg <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                end
                if (cmd.load && crystal_count_reg < CNT_MAX)
                begin
                    crystal_count_reg <= crystal_count_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign lat_fraction     = lat_reg;
    assign too_few          = few_reg;
    assign zero_denominator = zden_reg;

endmodule

/* design/lateral_shower_moment.sv */
// Top level of the lateral shower moment block: APB register, controller, datapath.
// Depends on lsm_pkg, lsm_ctrl and lsm_datapath.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   in        | in_valid / in_ready   | energy, radius, last
//   out       | out_valid / out_ready | lat_fraction, too_few, zero_denominator
//   apb       | psel, penable, pready | paddr, pwrite, pwdata, prdata
//
// A crystal passes through accept, square, multiply and accumulate; the two
// multiplier stages of the accumulate path set this sequence.
// The last crystal of a cluster then adds the product, the denominator, 16 divider
// steps of one quotient bit each, and the output load.
// The output register holds a result until taken; a stalled result holds the block.
// rst_n clears the controller and the cluster sums and sets spacing_squared to 25600.
module lateral_shower_moment
#(
    parameter int MAX_CRYSTALS = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsm_pkg::APB_AW-1:0]    paddr,
    input  logic [lsm_pkg::APB_DW-1:0]    pwdata,
    output logic [lsm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lsm_pkg::ENERGY_W-1:0]  energy,
    input  logic [lsm_pkg::RADIUS_W-1:0]  radius,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsm_pkg::FRAC_W-1:0]    lat_fraction,
    output logic                          too_few,
    output logic                          zero_denominator
);
    import lsm_pkg::*;

    logic [SPACING_W-1:0] spacing_reg;
    logic                 reg_sel;
    cmd_t                 cmd;
    status_t              status;

    assign reg_sel = paddr[APB_AW-1] == REG_SPACING;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? APB_DW'(spacing_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            spacing_reg <= pwdata[SPACING_W-1:0];
        end
    end

    lsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lsm_datapath
    #(
        .MAX_CRYSTALS (MAX_CRYSTALS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .spacing_squared  (spacing_reg),
        .energy           (energy),
        .radius           (radius),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .lat_fraction     (lat_fraction),
        .too_few          (too_few),
        .zero_denominator (zero_denominator)
    );

endmodule

/* design/lsm_checker.sv */
// Port checker for the lateral shower moment block, bound to the top level.
// Depends on lsm_pkg and lateral_shower_moment_macros.svh.
`include "lateral_shower_moment_macros.svh"

module lsm_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsm_pkg::APB_AW-1:0]    paddr,
    input  logic [lsm_pkg::APB_DW-1:0]    pwdata,
    input  logic [lsm_pkg::APB_DW-1:0]    prdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [lsm_pkg::ENERGY_W-1:0]  energy,
    input  logic [lsm_pkg::RADIUS_W-1:0]  radius,
    input  logic                          last,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [lsm_pkg::FRAC_W-1:0]    lat_fraction,
    input  logic                          too_few,
    input  logic                          zero_denominator
);

    `LSM_ASSERT_IMPLY(a_flags_exclusive, clk, rst_n, out_valid, !(too_few && zero_denominator), "both result flags set")
    `LSM_ASSERT_IMPLY(a_flag_zero, clk, rst_n, out_valid && (too_few || zero_denominator), lat_fraction == '0, "flagged result not zero")
    `LSM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && !(out_valid && !$past(out_valid)), "item taken while busy")
    `LSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(lat_fraction), "result dropped before taken")

endmodule

bind lateral_shower_moment lsm_checker u_lsm_checker (.*);

/* tb/lateral_shower_moment_test.sv */
// Self-checking testbench for lateral_shower_moment: crystal items in, LAT results out.
// Predicts each result from its own ranking and divide, drives APB for spacing_squared.
// Depends on lsm_pkg and the lateral_shower_moment RTL.
module lateral_shower_moment_test;
    import lsm_pkg::*;

    localparam logic [APB_AW-1:0] SPACING_ADDR = APB_AW'(4 * int'(REG_SPACING));
    localparam int MAX_CRYSTALS     = 256;
    localparam int WIDE_W           = SUM_W + 2;
    localparam int QUO_W            = SUM_W + FRAC_W + 2;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int PHASE_ITEMS      = 40;

    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic              few;
        logic              zden;
    } lat_result_t;

    typedef enum int {
        VAL_FULL,
        VAL_LOW,
        VAL_TINY,
        VAL_HIGH,
        VAL_ZERO
    } value_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ENERGY_W-1:0]  energy = '0;
    logic [RADIUS_W-1:0]  radius = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FRAC_W-1:0]    lat_fraction;
    logic                 too_few;
    logic                 zero_denominator;

    logic [SPACING_W-1:0] spacing_sq = SPACING_RESET;
    logic [ENERGY_W-1:0]  lead_energy = '0;
    logic [RADIUS_W-1:0]  lead_radius = '0;
    logic [ENERGY_W-1:0]  runner_energy = '0;
    logic [RADIUS_W-1:0]  runner_radius = '0;
    logic [SUM_W-1:0]     spread_sum = '0;
    logic [8:0]           crystals_seen = '0;
    lat_result_t          pending_lat[$];

    int mismatches = 0;
    int idle_cycles = 0;
    int hold_request = 0;
    bit steady_flow = 1'b0;

    lateral_shower_moment uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .energy           (energy),
        .radius           (radius),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .lat_fraction     (lat_fraction),
        .too_few          (too_few),
        .zero_denominator (zero_denominator)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic add_spread(input logic [ENERGY_W-1:0] e, input logic [RADIUS_W-1:0] r);
        logic [TERM_W-1:0] term;
        logic [SUM_W:0]    total;
        term = TERM_W'(r) * TERM_W'(r) * TERM_W'(e);
        total = {1'b0, spread_sum} + (SUM_W + 1)'(term);
        spread_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
    endtask

    task automatic rank_crystal(input logic [ENERGY_W-1:0] e, input logic [RADIUS_W-1:0] r,
                                input logic is_last);
        lat_result_t        res;
        logic [WIDE_W-1:0]  core;
        logic [WIDE_W-1:0]  den;
        logic [QUO_W-1:0]   quotient;
        if (crystals_seen == 0)
        begin
            lead_energy = e;
            lead_radius = r;
        end
        else if (crystals_seen == 1)
        begin
            if (e > lead_energy)
            begin
                runner_energy = lead_energy;
                runner_radius = lead_radius;
                lead_energy = e;
                lead_radius = r;
            end
            else
            begin
                runner_energy = e;
                runner_radius = r;
            end
        end
        else if (e > lead_energy)
        begin
            add_spread(runner_energy, runner_radius);
            runner_energy = lead_energy;
            runner_radius = lead_radius;
            lead_energy = e;
            lead_radius = r;
        end
        else if (e > runner_energy)
        begin
            add_spread(runner_energy, runner_radius);
            runner_energy = e;
            runner_radius = r;
        end
        else
        begin
            add_spread(e, r);
        end
        if (crystals_seen < MAX_CRYSTALS)
            crystals_seen = crystals_seen + 1'b1;

        if (is_last)
        begin
            res = '0;
            if (crystals_seen < 3)
                res.few = 1'b1;
            else
            begin
                core = WIDE_W'(spacing_sq) * (WIDE_W'(lead_energy) + WIDE_W'(runner_energy));
                den = WIDE_W'(spread_sum) + core;
                if (den == '0)
                    res.zden = 1'b1;
                else if (WIDE_W'(spread_sum) >= den)
                    res.frac = '1;
                else
                begin
                    quotient = {2'b00, spread_sum, {FRAC_W{1'b0}}} / QUO_W'(den);
                    res.frac = quotient[FRAC_W-1:0];
                end
            end
            pending_lat.push_back(res);
            lead_energy = '0;
            lead_radius = '0;
            runner_energy = '0;
            runner_radius = '0;
            spread_sum = '0;
            crystals_seen = '0;
        end
    endtask

    task automatic send_crystal(input logic [ENERGY_W-1:0] e, input logic [RADIUS_W-1:0] r,
                                input logic is_last);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        energy <= e;
        radius <= r;
        last <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rank_crystal(e, r, is_last);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_lat.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_spacing(input logic [APB_DW-1:0] value);
        settle_block();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SPACING_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        spacing_sq = value[SPACING_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [ENERGY_W-1:0] draw_value(input value_mode_t mode);
        case (mode)
            VAL_LOW:  return ENERGY_W'($urandom_range(0, 255));
            VAL_TINY: return ENERGY_W'($urandom_range(0, 3));
            VAL_HIGH: return ENERGY_W'(65535 - $urandom_range(0, 3));
            VAL_ZERO: return '0;
            default:  return ENERGY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_cluster(input int length, input value_mode_t e_mode,
                                input value_mode_t r_mode);
        for (int i = 0; i < length; i++)
            send_crystal(draw_value(e_mode), draw_value(r_mode), i == length - 1);
    endtask

    task automatic test_short_clusters();
        send_crystal(16'hFFFF, 16'hFFFF, 1'b1);
        send_crystal(16'd100, 16'd5, 1'b0);
        send_crystal(16'd100, 16'd7, 1'b1);
        send_crystal(16'd0, 16'd0, 1'b0);
        send_crystal(16'd1, 16'hFFFF, 1'b1);
    endtask

    task automatic test_ranking();
        send_crystal(16'd50, 16'd10, 1'b0);
        send_crystal(16'd50, 16'd20, 1'b0);
        send_crystal(16'd50, 16'd30, 1'b1);
        send_crystal(16'd10, 16'd100, 1'b0);
        send_crystal(16'd20, 16'd200, 1'b0);
        send_crystal(16'd30, 16'd300, 1'b1);
        send_crystal(16'd30, 16'd1, 1'b0);
        send_crystal(16'd10, 16'd2, 1'b0);
        send_crystal(16'd20, 16'd3, 1'b0);
        send_crystal(16'd20, 16'd4, 1'b1);
        send_crystal(16'd0, 16'd0, 1'b0);
        send_crystal(16'd0, 16'hFFFF, 1'b0);
        send_crystal(16'd0, 16'hFFFF, 1'b1);
        send_crystal(16'hFFFF, 16'hFFFF, 1'b0);
        send_crystal(16'hFFFF, 16'hFFFF, 1'b0);
        send_crystal(16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    task automatic test_spacing_extremes();
        write_spacing('0);
        send_crystal(16'd5, 16'd100, 1'b0);
        send_crystal(16'd5, 16'd100, 1'b0);
        send_crystal(16'd5, 16'd100, 1'b1);
        send_crystal(16'd0, 16'd9, 1'b0);
        send_crystal(16'd0, 16'd9, 1'b0);
        send_crystal(16'd0, 16'd9, 1'b1);
        // upper data bits must be dropped by the register
        write_spacing(32'hFFFF_FFFF);
        send_crystal(16'd1, 16'd1, 1'b0);
        send_crystal(16'd1, 16'd1, 1'b0);
        send_crystal(16'd1, 16'd1, 1'b1);
        send_crystal(16'hFFFF, 16'd1, 1'b0);
        send_crystal(16'hFFFF, 16'd1, 1'b0);
        send_crystal(16'd1, 16'hFFFF, 1'b1);
        write_spacing(APB_DW'(SPACING_RESET));
    endtask

    task automatic test_long_cluster();
        steady_flow = 1'b1;
        for (int i = 0; i < MAX_CRYSTALS + 14; i++)
            send_crystal(16'hFFFF, 16'hFFFF, i == MAX_CRYSTALS + 13);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_clusters();
        int          sent;
        int          length;
        int          pick;
        value_mode_t e_mode;
        value_mode_t r_mode;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       write_spacing(APB_DW'($urandom_range(0, (1 << SPACING_W) - 1)));
                1:       write_spacing(APB_DW'($urandom_range(0, 255)));
                2:       write_spacing(APB_DW'((1 << SPACING_W) - 1));
                default: write_spacing(APB_DW'(SPACING_RESET));
            endcase
            steady_flow = (phase == 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    length = $urandom_range(1, 2);
                else if (pick < 85)
                    length = $urandom_range(3, 10);
                else
                    length = $urandom_range(11, 40);
                e_mode = value_mode_t'($urandom_range(0, 3));
                if ($urandom_range(0, 19) == 0)
                    e_mode = VAL_ZERO;
                r_mode = value_mode_t'($urandom_range(0, 4));
                send_cluster(length, e_mode, r_mode);
                sent += length;
            end
            steady_flow = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        settle_block();
        hold_request = HOLD_OFF_CYCLES;
        steady_flow = 1'b1;
        for (int i = 0; i < 15; i++)
            send_cluster($urandom_range(3, 5), VAL_LOW, VAL_LOW);
        steady_flow = 1'b0;
    endtask

    task automatic check_lat_result();
        lat_result_t want;
        if (pending_lat.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("unexpected result: lat_fraction %0d too_few %0b zero_denominator %0b",
                         lat_fraction, too_few, zero_denominator);
        end
        else
        begin
            want = pending_lat.pop_front();
            if (lat_fraction !== want.frac || too_few !== want.few ||
                zero_denominator !== want.zden)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             want.frac, want.few, want.zden,
                             lat_fraction, too_few, zero_denominator);
            end
        end
    endtask

    initial
    begin
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            gap = steady_flow ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_lat_result();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_clusters();
        test_ranking();
        test_spacing_extremes();
        test_long_cluster();
        test_random_clusters();
        test_backpressure();
        settle_block();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
